/* rtl/assert_macros.svh */
// Assertion helpers for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tlfs_pkg.sv */
`default_nettype none
package tlfs_pkg;
	localparam int NPROC    = 16;
	localparam int NIO      = 4;
	localparam int IDX_W    = $clog2(NPROC);
	localparam int IO_W     = $clog2(NIO);
	localparam int NIO_ENT  = NPROC * NIO;
	localparam int IOA_W    = IDX_W + IO_W;
	localparam int TIME_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] HQ_RESET = 8'd10;
	localparam logic [7:0] LQ_RESET = 8'd15;

	localparam logic [1:0] ACT_LOAD_PROC = 2'd0;
	localparam logic [1:0] ACT_LOAD_IO   = 2'd1;
	localparam logic [1:0] ACT_STEP      = 2'd2;

	localparam logic [1:0] OC_IDLE   = 2'd0;
	localparam logic [1:0] OC_DONE   = 2'd1;
	localparam logic [1:0] OC_IO     = 2'd2;
	localparam logic [1:0] OC_LOW    = 2'd3;

	localparam logic [1:0] ST_NEW    = 2'd0;
	localparam logic [1:0] ST_READY  = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;
	localparam logic [1:0] ST_IO     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_HQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LQ = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_ADMIT, S_IO_POP, S_IO_RD, S_IO_UPD,
		S_PICK, S_REM, S_UNTIL, S_ADV, S_FIN, S_IOCHK, S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  slot;
		logic [15:0] arrival_time;
		logic [15:0] cpu_need;
		logic [2:0]  io_total;
		logic [1:0]  io_slot;
		logic [15:0] io_start;
		logic [15:0] io_length;
	} item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic           empty;
		logic           full;
		logic [IDX_W:0] count;
	} q_stat_t;
endpackage
`default_nettype wire

/* rtl/tlfs_if.sv */
`default_nettype none
interface tlfs_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [3:0]  slot;
	logic [15:0] arrival_time;
	logic [15:0] cpu_need;
	logic [2:0]  io_total;
	logic [1:0]  io_slot;
	logic [15:0] io_start;
	logic [15:0] io_length;
	modport source (output valid, action, slot, arrival_time, cpu_need, io_total, io_slot,
		io_start, io_length, input ready);
	modport sink (input valid, action, slot, arrival_time, cpu_need, io_total, io_slot,
		io_start, io_length, output ready);
endinterface

interface tlfs_res_if;
	logic        valid;
	logic        ready;
	logic        idle;
	logic [3:0]  ran_slot;
	logic        from_low;
	logic [7:0]  run_length;
	logic [1:0]  outcome;
	logic [15:0] now;
	logic        all_done;
	modport source (output valid, idle, ran_slot, from_low, run_length, outcome, now,
		all_done, input ready);
	modport sink (input valid, idle, ran_slot, from_low, run_length, outcome, now,
		all_done, output ready);
endinterface

interface tlfs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] reg_index;
	logic [7:0] reg_data;
	modport source (output valid, reg_index, reg_data, input ready);
	modport sink (input valid, reg_index, reg_data, output ready);
endinterface
`default_nettype wire

/* rtl/tlfs_queue.sv */
`default_nettype none
module tlfs_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlfs_pkg::q_ctl_t               ctl,
	input  logic [tlfs_pkg::IDX_W-1:0]     wdata,
	output logic [tlfs_pkg::IDX_W-1:0]     rdata,
	output tlfs_pkg::q_stat_t              stat
);
	import tlfs_pkg::*;

	logic [IDX_W-1:0] mem_q [NPROC];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W:0]   cnt_q;
	logic [IDX_W-1:0] tail;
	logic             do_push;
	logic             do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (IDX_W+1)'(NPROC));
	assign stat.count = cnt_q;
	assign rdata      = mem_q[head_q];
	assign tail       = head_q + cnt_q[IDX_W-1:0];
	assign do_pop     = ctl.pop && !stat.empty;
	// drop a push onto a full queue
	assign do_push    = ctl.push && !stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_pop)
				head_q <= head_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[tail] <= wdata;
	end
endmodule
`default_nettype wire

/* rtl/two_level_feedback_scheduler.sv */
`default_nettype none
// Two-level feedback process scheduler.
// Channels: item (sink) takes load and step commands, result (source) returns
// exactly one result per item, cfg (sink) writes the high and low quantum
// registers; cfg is always ready and must only be written while the block idles.
// A load item passes through S_LOAD to S_OUT, where result valid rises.
// A step item walks all 16 process slots for arrivals, then pops each waiting I/O
// entry and counts it down through the single I/O table port (pop, read, update
// states), then dispatches and retires through the pick, remaining, until, advance,
// finish and I/O check states.
// One subtractor is shared by the time compares and the I/O countdown of the step.
// The block takes one item at a time: item.ready is low from transfer until the
// result transfers, so a stalled receiver holds the block and the result stays
// stable. Reset clears time, counters, queues and process progress and restores
// quanta of 10 and 15; the I/O table and the per-slot load data hold garbage
// until loaded.
module two_level_feedback_scheduler (
	input  logic       clk,
	input  logic       arst_n,
	tlfs_item_if.sink  item,
	tlfs_res_if.source result,
	tlfs_cfg_if.sink   cfg
);
	import tlfs_pkg::*;

	state_t state_q, state_d;
	item_t  item_q;

	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W:0]    io_cnt_q;
	logic [TIME_W-1:0] time_q;
	logic [IDX_W:0]    done_q;
	logic [IDX_W:0]    loaded_q;
	logic [7:0]        hq_q, lq_q, quant_q, exec_q;
	logic              low_q, has_io_q;
	logic [IOA_W-1:0]  addr_q;

	logic              ld_v_q   [NPROC];
	logic [1:0]        status_q [NPROC];
	logic [15:0]       used_q   [NPROC];
	logic [2:0]        nxio_q   [NPROC];
	logic [15:0]       arrive_q [NPROC];
	logic [15:0]       total_q  [NPROC];
	logic [2:0]        iocnt_q  [NPROC];

	logic [15:0]        begin_mem [NIO_ENT];
	logic signed [16:0] left_mem  [NIO_ENT];
	logic [15:0]        begin_rd_q;
	logic signed [16:0] left_rd_q;

	logic               res_idle_q, res_low_q;
	logic [3:0]         res_slot_q;
	logic [7:0]         res_len_q;
	logic [1:0]         res_oc_q;

	q_ctl_t            hi_ctl, lo_ctl, wt_ctl;
	q_stat_t           hi_stat, lo_stat, wt_stat;
	logic [IDX_W-1:0]  hi_head, lo_head, wt_head;

	// shared subtract unit
	logic signed [17:0] op_a, op_b, sub_r;
	logic               sub_neg, sub_zero;

	logic               item_xfer, res_xfer;
	logic               ld_io, left_we, begin_re, left_re;
	logic [IOA_W-1:0]   ld_addr, left_waddr, left_raddr, begin_raddr;
	logic signed [16:0] left_wdata;
	logic [2:0]         nx_cur, nx_prev;
	logic               has_io_now;
	logic [7:0]         exec_rem;

	tlfs_queue u_high (.clk(clk), .arst_n(arst_n), .ctl(hi_ctl), .wdata(idx_q),
		.rdata(hi_head), .stat(hi_stat));
	tlfs_queue u_low (.clk(clk), .arst_n(arst_n), .ctl(lo_ctl), .wdata(idx_q),
		.rdata(lo_head), .stat(lo_stat));
	tlfs_queue u_wait (.clk(clk), .arst_n(arst_n), .ctl(wt_ctl), .wdata(idx_q),
		.rdata(wt_head), .stat(wt_stat));

	assign item_xfer = item.valid && item.ready;
	assign res_xfer  = result.valid && result.ready;
	assign cfg.ready = 1'b1;

	assign nx_cur     = nxio_q[idx_q];
	assign nx_prev    = (nx_cur == 3'd0) ? 3'd0 : nx_cur - 3'd1;
	assign has_io_now = (iocnt_q[idx_q] != 3'd0) && (nx_cur < iocnt_q[idx_q]);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_ADMIT: begin
				op_a = {2'b00, time_q};
				op_b = {2'b00, arrive_q[idx_q]};
			end
			S_IO_UPD: begin
				op_a = {left_rd_q[16], left_rd_q};
				op_b = 18'sd1;
			end
			S_REM: begin
				op_a = {2'b00, total_q[idx_q]};
				op_b = {2'b00, used_q[idx_q]};
			end
			S_UNTIL: begin
				op_a = {2'b00, begin_rd_q};
				op_b = {2'b00, used_q[idx_q]};
			end
			S_FIN: begin
				op_a = {2'b00, used_q[idx_q]};
				op_b = {2'b00, total_q[idx_q]};
			end
			S_IOCHK: begin
				op_a = {2'b00, used_q[idx_q]};
				op_b = {2'b00, begin_rd_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end
	assign sub_r    = op_a - op_b;
	assign sub_neg  = sub_r[17];
	assign sub_zero = (sub_r == '0);

	always_comb begin
		if (sub_neg || sub_zero)
			exec_rem = 8'd0;
		else if (sub_r[16:8] != '0)
			exec_rem = quant_q;
		else if (sub_r[7:0] < quant_q)
			exec_rem = sub_r[7:0];
		else
			exec_rem = quant_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:
				if (item_xfer)
					state_d = (item.action == ACT_STEP) ? S_ADMIT : S_LOAD;
			S_LOAD:   state_d = S_OUT;
			S_ADMIT:
				if (idx_q == IDX_W'(NPROC - 1))
					state_d = S_IO_POP;
			S_IO_POP: state_d = (io_cnt_q == '0) ? S_PICK : S_IO_RD;
			S_IO_RD:  state_d = S_IO_UPD;
			S_IO_UPD: state_d = S_IO_POP;
			S_PICK:   state_d = (hi_stat.empty && lo_stat.empty) ? S_OUT : S_REM;
			S_REM:    state_d = S_UNTIL;
			S_UNTIL:  state_d = S_ADV;
			S_ADV:    state_d = S_FIN;
			S_FIN:    state_d = sub_neg ? S_IOCHK : S_OUT;
			S_IOCHK:  state_d = S_OUT;
			S_OUT:
				if (res_xfer)
					state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item.ready   = (state_q == S_IDLE);
		result.valid = (state_q == S_OUT);
		hi_ctl       = '0;
		lo_ctl       = '0;
		wt_ctl       = '0;
		begin_re     = 1'b0;
		left_re      = 1'b0;
		case (state_q)
			S_ADMIT:
				hi_ctl.push = ld_v_q[idx_q] && (status_q[idx_q] == ST_NEW) && !sub_neg;
			S_IO_POP:
				wt_ctl.pop = (io_cnt_q != '0);
			S_IO_RD:
				left_re = 1'b1;
			S_IO_UPD: begin
				hi_ctl.push = sub_neg || sub_zero;
				wt_ctl.push = !(sub_neg || sub_zero);
			end
			S_PICK: begin
				hi_ctl.pop = !hi_stat.empty;
				lo_ctl.pop = hi_stat.empty && !lo_stat.empty;
			end
			S_REM:
				begin_re = 1'b1;
			S_IOCHK: begin
				wt_ctl.push = has_io_q && !sub_neg;
				lo_ctl.push = !(has_io_q && !sub_neg);
			end
			default: begin
				hi_ctl = '0;
			end
		endcase
	end

	assign result.idle       = res_idle_q;
	assign result.ran_slot   = res_slot_q;
	assign result.from_low   = res_low_q;
	assign result.run_length = res_len_q;
	assign result.outcome    = res_oc_q;
	assign result.now        = time_q;
	assign result.all_done   = (done_q == loaded_q);

	// I/O table
	assign ld_io       = (state_q == S_LOAD) && (item_q.action == ACT_LOAD_IO);
	assign ld_addr     = {item_q.slot, item_q.io_slot[IO_W-1:0]};
	assign left_we     = ld_io || (state_q == S_IO_UPD);
	assign left_waddr  = ld_io ? ld_addr : addr_q;
	assign left_wdata  = ld_io ? $signed({1'b0, item_q.io_length}) : sub_r[16:0];
	assign left_raddr  = {idx_q, nx_prev[IO_W-1:0]};
	assign begin_raddr = {idx_q, nx_cur[IO_W-1:0]};

	always_ff @(posedge clk) begin
		if (ld_io)
			begin_mem[ld_addr] <= item_q.io_start;
		if (left_we)
			left_mem[left_waddr] <= left_wdata;
		if (begin_re)
			begin_rd_q <= begin_mem[begin_raddr];
		if (left_re)
			left_rd_q <= left_mem[left_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			io_cnt_q <= '0;
			time_q   <= '0;
			done_q   <= '0;
			loaded_q <= '0;
			hq_q     <= HQ_RESET;
			lq_q     <= LQ_RESET;
			quant_q  <= '0;
			exec_q   <= '0;
			low_q    <= 1'b0;
			has_io_q <= 1'b0;
			addr_q   <= '0;
			for (int i = 0; i < NPROC; i++) begin
				ld_v_q[i]   <= 1'b0;
				status_q[i] <= ST_NEW;
				used_q[i]   <= '0;
				nxio_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.reg_index)
					REG_HQ:  hq_q <= cfg.reg_data;
					REG_LQ:  lq_q <= cfg.reg_data;
					default: hq_q <= hq_q;
				endcase
			end
			case (state_q)
				S_IDLE:
					idx_q <= '0;
				S_LOAD:
					if (item_q.action == ACT_LOAD_PROC && !ld_v_q[item_q.slot]) begin
						ld_v_q[item_q.slot] <= 1'b1;
						loaded_q <= loaded_q + 1'b1;
					end
				S_ADMIT: begin
					if (hi_ctl.push)
						status_q[idx_q] <= ST_READY;
					idx_q    <= idx_q + 1'b1;
					io_cnt_q <= wt_stat.count;
				end
				S_IO_POP:
					if (io_cnt_q != '0) begin
						idx_q    <= wt_head;
						io_cnt_q <= io_cnt_q - 1'b1;
					end
				S_IO_RD:
					addr_q <= left_raddr;
				S_IO_UPD:
					if (hi_ctl.push)
						status_q[idx_q] <= ST_READY;
				S_PICK:
					if (!hi_stat.empty) begin
						idx_q   <= hi_head;
						quant_q <= hq_q;
						low_q   <= 1'b0;
					end else if (!lo_stat.empty) begin
						idx_q   <= lo_head;
						quant_q <= lq_q;
						low_q   <= 1'b1;
					end else begin
						time_q <= time_q + 1'b1;
					end
				S_REM: begin
					exec_q   <= exec_rem;
					has_io_q <= has_io_now;
				end
				S_UNTIL:
					// cut the slice at the next I/O start
					if (has_io_q && !sub_neg && sub_r[16:8] == '0 && sub_r[7:0] <= exec_q)
						exec_q <= sub_r[7:0];
				S_ADV: begin
					used_q[idx_q] <= used_q[idx_q] + {8'd0, exec_q};
					time_q        <= time_q + {8'd0, exec_q};
				end
				S_FIN:
					if (!sub_neg) begin
						status_q[idx_q] <= ST_DONE;
						done_q          <= done_q + 1'b1;
					end
				S_IOCHK:
					if (has_io_q && !sub_neg) begin
						status_q[idx_q] <= ST_IO;
						nxio_q[idx_q]   <= nxio_q[idx_q] + 3'd1;
					end
				default:
					idx_q <= idx_q;
			endcase
		end
	end

	// load data and result payload
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			item_q.action       <= item.action;
			item_q.slot         <= item.slot;
			item_q.arrival_time <= item.arrival_time;
			item_q.cpu_need     <= item.cpu_need;
			item_q.io_total     <= item.io_total;
			item_q.io_slot      <= item.io_slot;
			item_q.io_start     <= item.io_start;
			item_q.io_length    <= item.io_length;
		end
		if (state_q == S_LOAD && item_q.action == ACT_LOAD_PROC) begin
			arrive_q[item_q.slot] <= item_q.arrival_time;
			total_q[item_q.slot]  <= item_q.cpu_need;
			iocnt_q[item_q.slot]  <= (item_q.io_total > 3'(NIO)) ? 3'(NIO) : item_q.io_total;
		end
		case (state_q)
			S_LOAD: begin
				res_idle_q <= 1'b0;
				res_slot_q <= '0;
				res_low_q  <= 1'b0;
				res_len_q  <= '0;
				res_oc_q   <= OC_IDLE;
			end
			S_PICK: begin
				res_idle_q <= 1'b1;
				res_slot_q <= '0;
				res_low_q  <= 1'b0;
				res_len_q  <= '0;
				res_oc_q   <= OC_IDLE;
			end
			S_FIN: begin
				res_idle_q <= 1'b0;
				res_slot_q <= idx_q;
				res_low_q  <= low_q;
				res_len_q  <= exec_q;
				res_oc_q   <= OC_DONE;
			end
			S_IOCHK:
				res_oc_q <= (has_io_q && !sub_neg) ? OC_IO : OC_LOW;
			default:
				res_oc_q <= res_oc_q;
		endcase
	end

`include "assert_macros.svh"

	`ASSERT_IMPL(a_no_take_while_pending, item.ready, !result.valid, "item taken with result pending")
	`ASSERT_IMPL(a_done_le_loaded, 1'b1, done_q <= loaded_q, "more finished than loaded")
	`ASSERT_NEXT(a_busy_after_take, item_xfer, !item.ready, "ready held after transfer")
	`ASSERT_IMPL(a_pop_in_pick, hi_ctl.pop || lo_ctl.pop, state_q == S_PICK, "dispatch pop outside pick")
endmodule
`default_nettype wire
